[sv/b2b_pkg.sv]
`timescale 1ns / 1ps

package b2b_pkg;

	// Input transaction payload.
	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        is_last;
	} in_item_t;

	// Output transaction payload.
	typedef struct packed {
		logic [63:0] digest_word;
		logic [3:0]  digest_bytes;
		logic        last_word;
	} out_item_t;

	// Initialization vector.
	localparam logic [63:0] IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};

	localparam logic [63:0] PARAM_BASE = 64'h0000000001010000;
	localparam logic [63:0] FINAL_FLAG = '1;

	// Message word schedule, flattened by round and position.
	localparam logic [3:0] SIGMA [10][16] = '{
		'{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		  4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
		'{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
		  4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
		'{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
		  4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
		'{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
		  4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
		'{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
		  4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
		'{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
		  4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
		'{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
		  4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
		'{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
		  4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
		'{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
		  4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
		'{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
		  4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}};

	// Work vector indexes a, b, c, d for each of the eight G steps of a round.
	localparam logic [3:0] G_A [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd0, 4'd1, 4'd2, 4'd3};
	localparam logic [3:0] G_B [8] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd5, 4'd6, 4'd7, 4'd4};
	localparam logic [3:0] G_C [8] = '{4'd8, 4'd9, 4'd10, 4'd11, 4'd10, 4'd11, 4'd8, 4'd9};
	localparam logic [3:0] G_D [8] = '{4'd12, 4'd13, 4'd14, 4'd15, 4'd15, 4'd12, 4'd13, 4'd14};

	// One G quadruple travelling to and from the mixing unit.
	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} quad_t;

endpackage

[sv/b2b_mix.sv]
`timescale 1ns / 1ps

// One half of the BLAKE2b G function; the sequencer applies it twice per G step.
module b2b_mix (
	input  b2b_pkg::quad_t  quad_in,
	input  logic [63:0]     msg,
	input  logic            second,
	output b2b_pkg::quad_t  quad_out
);

	logic [63:0] a_n, d_x, c_n, b_x;

	always_comb begin
		a_n = quad_in.a + quad_in.b + msg;
		d_x = quad_in.d ^ a_n;
		quad_out.a = a_n;
		quad_out.d = second ? {d_x[15:0], d_x[63:16]} : {d_x[31:0], d_x[63:32]};
		c_n = quad_in.c + quad_out.d;
		b_x = quad_in.b ^ c_n;
		quad_out.c = c_n;
		quad_out.b = second ? {b_x[62:0], b_x[63]} : {b_x[23:0], b_x[63:24]};
	end

endmodule

[sv/blake2b_hash.sv]
`timescale 1ns / 1ps
// Unkeyed BLAKE2b hash, one message word per input transaction, one shared half-G unit.
// A plain word is appended in ST_FIN; the next word is taken once the block is back in ST_IDLE.
// A word with bytes beyond a full block adds a compression: load, 192 half-steps
// (12 rounds x 8 G steps x 2), feed-forward and the append of the remaining bytes.
// A last word gives its first digest word after the final compression, then one word per
// unstalled cycle. Reset (arst_n low) clears the message state; out_len resets to 64.
module blake2b_hash (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  b2b_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output b2b_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [6:0]          cfg_data
);

	typedef enum logic [2:0] {ST_IDLE, ST_INIT, ST_MIX, ST_FEED, ST_FIN, ST_OUT} state_t;

	state_t          state_q;
	logic [6:0]      out_len_q;
	logic [63:0]     h_q [8];
	logic [63:0]     v_q [16];
	logic [63:0]     m_q [16];
	logic [127:0]    cnt_q;
	logic [7:0]      fill_q;
	logic            in_msg_q;
	logic            final_q;
	logic [3:0]      round_q;
	logic [2:0]      step_q;
	logic            half_q;
	logic [2:0]      oidx_q;
	logic [63:0]     word_q;
	logic [3:0]      nb_q;
	logic            last_q;
	logic [6:0]      dlen_q;

	b2b_pkg::quad_t  quad_in, quad_out;
	logic [63:0]     msg;
	logic [3:0]      sig_round;
	logic [6:0]      len_eff;
	logic [3:0]      nb_in;
	logic [63:0]     h_start [8];
	logic [127:0]    cnt_start;
	logic [7:0]      fill_start;
	logic            accept;
	logic [6:0]      rem;
	logic [7:0]      space;
	logic            spill;
	logic [3:0]      take_n;
	logic [7:0]      byte_pos [8];
	logic            out_load;

	// Effective digest length from the register.
	always_comb begin
		if (out_len_q == 7'd0) begin
			len_eff = 7'd1;
		end else if (out_len_q > 7'd64) begin
			len_eff = 7'd64;
		end else begin
			len_eff = out_len_q;
		end
	end

	assign nb_in = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign cfg_ready = 1'b1;
	assign fill_start = in_msg_q ? fill_q : 8'd0;
	assign cnt_start = in_msg_q ? cnt_q : 128'd0;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			h_start[i] = in_msg_q ? h_q[i] : b2b_pkg::IV[i];
		end
		if (!in_msg_q) begin
			h_start[0] = b2b_pkg::IV[0] ^ b2b_pkg::PARAM_BASE ^ {57'd0, len_eff};
		end
	end

	// Bytes of the pending word that still fit in the block.
	assign space = 8'd128 - fill_q;
	assign spill = ({4'd0, nb_q} > space);
	assign take_n = spill ? space[3:0] : nb_q;
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			byte_pos[i] = fill_q + 8'(i);
		end
	end

	// Operand selection for the mixing unit.
	assign sig_round = (round_q >= 4'd10) ? round_q - 4'd10 : round_q;
	always_comb begin
		quad_in.a = v_q[b2b_pkg::G_A[step_q]];
		quad_in.b = v_q[b2b_pkg::G_B[step_q]];
		quad_in.c = v_q[b2b_pkg::G_C[step_q]];
		quad_in.d = v_q[b2b_pkg::G_D[step_q]];
		msg = m_q[b2b_pkg::SIGMA[sig_round][{step_q, half_q}]];
	end

	b2b_mix u_mix (
		.quad_in  (quad_in),
		.msg      (msg),
		.second   (half_q),
		.quad_out (quad_out)
	);

	assign rem = dlen_q - {1'b0, oidx_q, 3'b000};
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	// Sequencer, message state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_len_q <= 7'd64;
			cnt_q     <= '0;
			fill_q    <= '0;
			in_msg_q  <= 1'b0;
			out_valid <= 1'b0;
			final_q   <= 1'b0;
			round_q   <= '0;
			step_q    <= '0;
			half_q    <= 1'b0;
			oidx_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				out_len_q <= cfg_data;
			end
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_msg_q <= 1'b1;
						for (int i = 0; i < 8; i++) h_q[i] <= h_start[i];
						word_q <= in_data.data_word;
						nb_q   <= nb_in;
						last_q <= in_data.is_last;
						if (!in_msg_q) begin
							for (int i = 0; i < 16; i++) m_q[i] <= '0;
						end
						cnt_q   <= cnt_start;
						fill_q  <= fill_start;
						state_q <= ST_FIN;
					end
				end
				ST_INIT: begin
					for (int i = 0; i < 8; i++) begin
						v_q[i] <= h_q[i];
					end
					for (int i = 0; i < 4; i++) begin
						v_q[i + 8] <= b2b_pkg::IV[i];
					end
					v_q[12] <= b2b_pkg::IV[4] ^ cnt_q[63:0];
					v_q[13] <= b2b_pkg::IV[5] ^ cnt_q[127:64];
					v_q[14] <= b2b_pkg::IV[6] ^ (final_q ? b2b_pkg::FINAL_FLAG : 64'd0);
					v_q[15] <= b2b_pkg::IV[7];
					round_q <= '0;
					step_q  <= '0;
					half_q  <= 1'b0;
					state_q <= ST_MIX;
				end
				ST_MIX: begin
					v_q[b2b_pkg::G_A[step_q]] <= quad_out.a;
					v_q[b2b_pkg::G_B[step_q]] <= quad_out.b;
					v_q[b2b_pkg::G_C[step_q]] <= quad_out.c;
					v_q[b2b_pkg::G_D[step_q]] <= quad_out.d;
					half_q <= !half_q;
					if (half_q) begin
						step_q <= step_q + 3'd1;
						if (step_q == 3'd7) begin
							round_q <= round_q + 4'd1;
							if (round_q == 4'd11) begin
								state_q <= ST_FEED;
							end
						end
					end
				end
				ST_FEED: begin
					// Feed-forward once the last half-step has been written back.
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i + 8];
					end
					if (final_q) begin
						state_q <= ST_OUT;
					end else begin
						for (int i = 0; i < 16; i++) m_q[i] <= '0;
						fill_q  <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// Append the bytes that fit; a full block with bytes left over is compressed before
					// the rest is appended, and a last word that fits starts the final compression.
					for (int i = 0; i < 8; i++) begin
						if (4'(i) < take_n) begin
							m_q[byte_pos[i][6:3]][{byte_pos[i][2:0], 3'b000} +: 8]
								<= word_q[8 * i +: 8];
						end
					end
					fill_q <= fill_q + {4'd0, take_n};
					if (spill) begin
						word_q  <= word_q >> {take_n, 3'b000};
						nb_q    <= nb_q - take_n;
						final_q <= 1'b0;
						cnt_q   <= cnt_q + 128'd128;
						state_q <= ST_INIT;
					end else if (last_q) begin
						final_q <= 1'b1;
						cnt_q   <= cnt_q + {120'd0, fill_q + {4'd0, nb_q}};
						dlen_q  <= len_eff;
						oidx_q  <= '0;
						state_q <= ST_INIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						out_data.digest_word <= (rem >= 7'd8) ? h_q[oidx_q] :
							h_q[oidx_q] & ~(64'hFFFFFFFFFFFFFFFF << {rem[2:0], 3'b000});
						out_data.digest_bytes <= (rem >= 7'd8) ? 4'd8 : {1'b0, rem[2:0]};
						out_data.last_word <= (rem <= 7'd8);
						oidx_q <= oidx_q + 3'd1;
						if (rem <= 7'd8) begin
							in_msg_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The input side is closed while a compression runs.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MIX) |-> in_stall)
		else $error("input accepted during compression");

	// A digest word is only produced after a final compression.
	a_out_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("digest word outside output phase");

	// The block fill never exceeds one block.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 8'd128)
		else $error("block fill overflow");

endmodule

[tb/blake2b_checker.sv]
`timescale 1ns / 1ps

module blake2b_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  b2b_pkg::in_item_t   in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  b2b_pkg::out_item_t  out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [6:0]          cfg_data,
	output int                  fail_count,
	output int                  digests_pending
);

	localparam logic [63:0] IV_W [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
	localparam logic [63:0] PARAM_WORD = 64'h0000000001010000;
	localparam int MSG_ORDER [10][16] = '{
		'{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
		'{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
		'{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
		'{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
		'{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
		'{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
		'{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
		'{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
		'{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
		'{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

	// Predicted hashing state.
	logic [6:0]   digest_len_reg;
	logic [63:0]  hstate [8];
	logic [127:0] byte_total;
	logic [63:0]  msg_block [16];
	int           block_fill;
	bit           msg_open;
	logic [63:0]  vw [16];
	b2b_pkg::out_item_t expected_digest_q [$];

	function automatic int eff_len(logic [6:0] v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return int'(v);
	endfunction

	function automatic logic [63:0] rotr(logic [63:0] w, int c);
		return (w >> c) | (w << (64 - c));
	endfunction

	task automatic g_mix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
		vw[a] = vw[a] + vw[b] + x;
		vw[d] = rotr(vw[d] ^ vw[a], 32);
		vw[c] = vw[c] + vw[d];
		vw[b] = rotr(vw[b] ^ vw[c], 24);
		vw[a] = vw[a] + vw[b] + y;
		vw[d] = rotr(vw[d] ^ vw[a], 16);
		vw[c] = vw[c] + vw[d];
		vw[b] = rotr(vw[b] ^ vw[c], 63);
	endtask

	task automatic compress_block(logic [63:0] flag);
		int s;
		for (int i = 0; i < 8; i++) begin
			vw[i] = hstate[i];
			vw[i + 8] = IV_W[i];
		end
		vw[12] ^= byte_total[63:0];
		vw[13] ^= byte_total[127:64];
		vw[14] ^= flag;
		for (int r = 0; r < 12; r++) begin
			s = r % 10;
			g_mix(0, 4, 8, 12, msg_block[MSG_ORDER[s][0]], msg_block[MSG_ORDER[s][1]]);
			g_mix(1, 5, 9, 13, msg_block[MSG_ORDER[s][2]], msg_block[MSG_ORDER[s][3]]);
			g_mix(2, 6, 10, 14, msg_block[MSG_ORDER[s][4]], msg_block[MSG_ORDER[s][5]]);
			g_mix(3, 7, 11, 15, msg_block[MSG_ORDER[s][6]], msg_block[MSG_ORDER[s][7]]);
			g_mix(0, 5, 10, 15, msg_block[MSG_ORDER[s][8]], msg_block[MSG_ORDER[s][9]]);
			g_mix(1, 6, 11, 12, msg_block[MSG_ORDER[s][10]], msg_block[MSG_ORDER[s][11]]);
			g_mix(2, 7, 8, 13, msg_block[MSG_ORDER[s][12]], msg_block[MSG_ORDER[s][13]]);
			g_mix(3, 4, 9, 14, msg_block[MSG_ORDER[s][14]], msg_block[MSG_ORDER[s][15]]);
		end
		for (int i = 0; i < 8; i++) hstate[i] ^= vw[i] ^ vw[i + 8];
	endtask

	task automatic clear_msg();
		byte_total = '0;
		foreach (msg_block[i]) msg_block[i] = '0;
		block_fill = 0;
	endtask

	// Absorbs one message word and queues the digest words on the last one.
	task automatic absorb_word(b2b_pkg::in_item_t it);
		int nb, len, words, rem;
		b2b_pkg::out_item_t d;
		nb = (it.byte_count > 8) ? 8 : int'(it.byte_count);
		if (!msg_open) begin
			foreach (hstate[i]) hstate[i] = IV_W[i];
			hstate[0] ^= PARAM_WORD ^ 64'(eff_len(digest_len_reg));
			clear_msg();
			msg_open = 1;
		end
		for (int i = 0; i < nb; i++) begin
			if (block_fill >= 128) begin
				byte_total += 128;
				compress_block('0);
				foreach (msg_block[k]) msg_block[k] = '0;
				block_fill = 0;
			end
			msg_block[block_fill / 8] |=
				64'(it.data_word[8 * i +: 8]) << (8 * (block_fill % 8));
			block_fill++;
		end
		if (it.is_last) begin
			byte_total += 128'(block_fill);
			compress_block('1);
			len = eff_len(digest_len_reg);
			words = (len + 7) / 8;
			for (int i = 0; i < words; i++) begin
				rem = len - 8 * i;
				d.digest_bytes = (rem > 8) ? 4'd8 : 4'(rem);
				d.digest_word = hstate[i];
				if (rem < 8) d.digest_word &= (64'd1 << (8 * rem)) - 1;
				d.last_word = (i + 1 == words);
				expected_digest_q.push_back(d);
			end
			clear_msg();
			msg_open = 0;
		end
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		digests_pending = 0;
		digest_len_reg = 7'd64;
		msg_open = 0;
		foreach (hstate[i]) hstate[i] = '0;
		clear_msg();
	end

	// Watch all three channels at each rising edge.
	always @(posedge clk) begin
		b2b_pkg::out_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) digest_len_reg <= cfg_data;
			if (in_valid && !in_stall) absorb_word(in_data);
			if (out_valid && !out_stall) begin
				if (expected_digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", out_data.digest_word, '0);
				end else begin
					want = expected_digest_q.pop_front();
					if (out_data.digest_word !== want.digest_word)
						report_mismatch("digest_word", out_data.digest_word, want.digest_word);
					if (out_data.digest_bytes !== want.digest_bytes)
						report_mismatch("digest_bytes", out_data.digest_bytes, want.digest_bytes);
					if (out_data.last_word !== want.last_word)
						report_mismatch("last_word", out_data.last_word, want.last_word);
				end
			end
		end
		digests_pending = expected_digest_q.size();
	end
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int CYCLE_LIMIT = 1500000;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	b2b_pkg::in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	b2b_pkg::out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [6:0] cfg_data;
	int         fail_count;
	int         digests_pending;
	int         send_idle_pct;
	int         recv_stall_pct;
	bit         hold_recv;
	int         cycle_count;

	blake2b_hash DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	blake2b_checker checker_inst (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .digests_pending(digests_pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Receiver stall pattern, with an optional long hold-off.
	always @(posedge clk) begin
		if (hold_recv) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Global timeout.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Sends one word, then idles at random before the next one.
	task automatic send_word(logic [63:0] w, int nb, bit last);
		in_valid <= 1'b1;
		in_data <= '{data_word: w, byte_count: 4'(nb), is_last: last};
		do @(posedge clk); while (in_stall);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
	endtask

	task automatic send_message(int nwords, bit mixed_counts);
		int nb;
		for (int i = 0; i < nwords; i++) begin
			nb = (mixed_counts && $urandom_range(3) == 0) ? $urandom_range(15) : 8;
			if (i == nwords - 1) nb = $urandom_range(8);
			send_word({$urandom, $urandom}, nb, i == nwords - 1);
		end
	endtask

	task automatic drain_and_idle();
		in_valid <= 1'b0;
		while (digests_pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_len(logic [6:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		int lens [6] = '{64, 1, 0, 127, 32, 20};
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 7'd64;
		hold_recv = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycle_count = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, extremes, block boundaries, odd counts.
		send_word('1, 0, 1);
		send_word('1, 8, 1);
		send_word('0, 15, 1);
		for (int i = 0; i < 16; i++) send_word({$urandom, $urandom}, 8, i == 15);
		send_word(64'h0123456789ABCDEF, 3, 0);
		send_word(64'hFEDCBA9876543210, 0, 0);
		send_word(64'hAAAAAAAA55555555, 9, 1);
		drain_and_idle();

		// Random phases over several digest lengths and idling mixes.
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			write_len((ph == 4) ? 7'($urandom_range(1, 64)) : 7'(lens[ph]));
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 87; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 87; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			if (ph == 1) begin
				// Long receiver hold-off while messages keep coming.
				hold_recv = 1;
				fork
					begin repeat (3000) @(posedge clk); hold_recv = 0; end
				join_none
			end
			while (sent < 70 * (ph + 1)) begin
				int n;
				n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 6);
				send_message(n, $urandom_range(1));
				sent += n;
			end
			// Sender pauses until all digests are back.
			drain_and_idle();
		end

		drain_and_idle();
		if (fail_count == 0 && digests_pending == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
